[sv/gw_pkg.sv]
// graph walk package: field widths, item codes and the command/status structs
// shared by the controller and the datapath; no dependencies
package gw_pkg;

	localparam int NODE_W   = 5;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WALK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// which node drives the degree read and the neighbor table address
	typedef enum logic [1:0] {
		SEL_A   = 2'd0,
		SEL_B   = 2'd1,
		SEL_CUR = 2'd2
	} node_sel_t;

	typedef enum logic {
		OUT_STATUS = 1'b0,
		OUT_PEND   = 1'b1
	} out_src_t;

	typedef struct packed {
		node_sel_t              deg_sel;
		logic                   du_latch;
		logic                   deg_clear;
		logic                   edge_wr;
		logic                   walk_init;
		logic                   pop;
		logic                   cur_latch;
		logic                   load_start;
		logic                   load_rd;
		logic                   scan_start;
		logic                   scan_step;
		logic                   pick;
		logic                   out_load;
		out_src_t               out_src;
		logic [STATUS_W-1:0]    out_status;
		logic                   out_last;
	} gw_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              a_ok;
		logic              b_ok;
		logic              room;
		logic              list_empty;
		logic              out_free;
		logic              pend_v;
		logic              idx_end;
		logic              have_best;
	} gw_stat_t;

endpackage

[sv/gw_if.sv]
// channel interfaces of the graph walk block: input item and result item
// depends on gw_pkg for the field widths
interface gw_in_if
	import gw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, output mode, output node_a, output node_b, input ready);
	modport sink (input valid, input mode, input node_a, input node_b, output ready);
endinterface

interface gw_out_if
	import gw_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [NODE_W-1:0]   visited_node;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, output visited_node, output status, output last, input ready);
	modport sink (input valid, input visited_node, input status, input last, output ready);
endinterface

[sv/graph_walk_bfs_dfs.sv]
// graph walk top level: joins the controller and the datapath to the channels
// depends on gw_pkg, gw_if, gw_ctrl and gw_dp
//
// Holds an undirected graph of NODES nodes (numbered from 1) with up to
// MAX_DEGREE neighbors per node and walks it breadth-first (walk_kind 0,
// queue, ascending neighbors) or depth-first (walk_kind 1, stack, descending
// neighbors, marked when pushed). Items are taken one at a time; a result may
// still wait at the output while the next item is accepted. For each explored
// node the neighbor row scan in the datapath picks the next neighbor in sorted
// order with one pass over the row, one entry a cycle.
module graph_walk_bfs_dfs
	import gw_pkg::*;
#(
	parameter int NODES      = 16,
	parameter int MAX_DEGREE = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	gw_in_if.sink    item,
	gw_out_if.source result,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	gw_cmd_t  cmd;
	gw_stat_t stat;
	logic     ready;
	logic     accept;

	assign item.ready = ready;
	assign accept     = item.valid && ready;

	gw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.ready  (ready),
		.cmd    (cmd)
	);

	gw_dp #(
		.NODES      (NODES),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (item.mode),
		.node_a     (item.node_a),
		.node_b     (item.node_b),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_node   (result.visited_node),
		.out_status (result.status),
		.out_last   (result.last)
	);

endmodule

[sv/gw_ctrl.sv]
// graph walk controller: one-hot state machine that sequences edge adds,
// clears and walks; depends on gw_pkg for the command and status structs
module gw_ctrl
	import gw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  gw_stat_t stat,
	output logic     ready,
	output gw_cmd_t  cmd
);

	typedef enum logic [14:0] {
		S_IDLE       = 15'h0001,
		S_DECODE     = 15'h0002,
		S_EDGE_A     = 15'h0004,
		S_EDGE_B     = 15'h0008,
		S_EDGE_W1    = 15'h0010,
		S_EDGE_W2    = 15'h0020,
		S_RESULT     = 15'h0040,
		S_WALK_INIT  = 15'h0080,
		S_POP        = 15'h0100,
		S_TAKE       = 15'h0200,
		S_LOAD_START = 15'h0400,
		S_LOAD       = 15'h0800,
		S_SCAN       = 15'h1000,
		S_PICK       = 15'h2000,
		S_FINAL      = 15'h4000
	} state_t;

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		st_d        = st_q;
		cmd         = '0;
		cmd.deg_sel = SEL_CUR;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (stat.mode)
					MODE_EDGE: begin
						if (stat.a_ok && stat.b_ok) begin
							state_d = S_EDGE_A;
						end else begin
							st_d    = ST_RANGE;
							state_d = S_RESULT;
						end
					end
					MODE_WALK: begin
						if (stat.a_ok) begin
							state_d = S_WALK_INIT;
						end else begin
							st_d    = ST_RANGE;
							state_d = S_RESULT;
						end
					end
					MODE_CLEAR: begin
						cmd.deg_clear = 1'b1;
						st_d          = ST_OK;
						state_d       = S_RESULT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_EDGE_A: begin
				cmd.deg_sel  = SEL_A;
				cmd.du_latch = 1'b1;
				state_d      = S_EDGE_B;
			end
			S_EDGE_B: begin
				cmd.deg_sel = SEL_B;
				if (stat.room) begin
					state_d = S_EDGE_W1;
				end else begin
					st_d    = ST_FULL;
					state_d = S_RESULT;
				end
			end
			S_EDGE_W1: begin
				cmd.deg_sel = SEL_A;
				cmd.edge_wr = 1'b1;
				state_d     = S_EDGE_W2;
			end
			S_EDGE_W2: begin
				cmd.deg_sel = SEL_B;
				cmd.edge_wr = 1'b1;
				st_d        = ST_OK;
				state_d     = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = OUT_STATUS;
					cmd.out_status = st_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = S_POP;
			end
			S_POP: begin
				if (stat.list_empty) begin
					state_d = S_FINAL;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				// the node before this one goes out now, it is not the last
				if (!stat.pend_v || stat.out_free) begin
					cmd.cur_latch  = 1'b1;
					cmd.out_load   = stat.pend_v;
					cmd.out_src    = OUT_PEND;
					cmd.out_status = ST_OK;
					state_d        = S_LOAD_START;
				end
			end
			S_LOAD_START: begin
				cmd.load_start = 1'b1;
				state_d        = S_LOAD;
			end
			S_LOAD: begin
				if (stat.idx_end) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.load_rd = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.idx_end) begin
					state_d = S_PICK;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = stat.have_best ? S_SCAN : S_POP;
			end
			S_FINAL: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = OUT_PEND;
					cmd.out_status = ST_OK;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[sv/gw_dp.sv]
// graph walk datapath: neighbor table, degree counts, visited marks, work list,
// neighbor row scan and output register; depends on gw_pkg
module gw_dp
	import gw_pkg::*;
#(
	parameter int NODES      = 16,
	parameter int MAX_DEGREE = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [MODE_W-1:0]   mode,
	input  logic [NODE_W-1:0]   node_a,
	input  logic [NODE_W-1:0]   node_b,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  gw_cmd_t             cmd,
	output gw_stat_t            stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [NODE_W-1:0]   out_node,
	output logic [STATUS_W-1:0] out_status,
	output logic                out_last
);

	localparam int NIW = $clog2(NODES);
	localparam int PW  = $clog2(NODES + 1);
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int RIW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int NE  = NODES * MAX_DEGREE;
	localparam int AW  = (NE > 1) ? $clog2(NE) : 1;
	localparam int CW  = NODE_W + 2;

	localparam logic [CW-1:0] NODES_C = CW'(NODES);
	localparam logic [DW:0]   MAXD_C  = (DW + 1)'(MAX_DEGREE);
	localparam logic [PW-1:0] NODES_P = PW'(NODES);

	function automatic logic node_ok(input logic [NODE_W-1:0] n);
		return (n != '0) && ({2'b00, n} <= NODES_C);
	endfunction

	function automatic logic [NIW-1:0] nidx(input logic [NODE_W-1:0] n);
		return NIW'(n - NODE_W'(1));
	endfunction

	logic                wk_q;
	logic [MODE_W-1:0]   mode_q;
	logic [NODE_W-1:0]   a_q, b_q;

	logic [DW-1:0]       deg_q [NODES];
	logic [DW-1:0]       du_q;
	logic [NODE_W-1:0]   nbr_mem [NE];
	logic [NODE_W-1:0]   nbr_rd_q;
	logic [NODE_W-1:0]   wl_mem [NODES];
	logic [NODE_W-1:0]   wl_rd_q;
	logic [PW-1:0]       head_q, tail_q;
	logic [NODES-1:0]    vis_q;

	logic [NODE_W-1:0]   cur_q;
	logic [DW-1:0]       dcur_q, idx_q;
	logic                ld_v_q;
	logic [RIW-1:0]      ld_idx_q;
	logic [NODE_W-1:0]   row_q [MAX_DEGREE];
	logic [NODE_W-1:0]   prev_q, best_q, pend_q;
	logic                have_prev_q, have_best_q, pend_v_q;

	logic                out_valid_q, out_last_q;
	logic [NODE_W-1:0]   out_node_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [NODE_W-1:0]   sel_node;
	logic [DW-1:0]       sel_deg;
	logic [DW-1:0]       nb_slot;
	logic [AW-1:0]       nb_addr;
	logic [NODE_W-1:0]   nb_wdata;
	logic [PW-1:0]       pop_pos;
	logic [NODE_W-1:0]   row_v;
	logic                after_prev, before_best, best_vis, push, out_free;
	logic                wl_we;
	logic [NIW-1:0]      wl_waddr;
	logic [NODE_W-1:0]   wl_wdata;

	always_comb begin
		unique case (cmd.deg_sel)
			SEL_A:   sel_node = a_q;
			SEL_B:   sel_node = b_q;
			default: sel_node = cur_q;
		endcase
	end

	assign sel_deg  = deg_q[nidx(sel_node)];
	assign nb_slot  = cmd.load_rd ? idx_q : sel_deg;
	assign nb_addr  = AW'(nidx(sel_node)) * AW'(MAX_DEGREE) + AW'(nb_slot);
	assign nb_wdata = (cmd.deg_sel == SEL_A) ? b_q : a_q;

	// stack pops from the top, queue from the head
	assign pop_pos  = wk_q ? (tail_q - PW'(1)) : head_q;

	assign row_v       = row_q[idx_q[RIW-1:0]];
	assign after_prev  = !have_prev_q || (wk_q ? (row_v < prev_q) : (row_v > prev_q));
	assign before_best = !have_best_q || (wk_q ? (row_v > best_q) : (row_v < best_q));
	assign best_vis    = vis_q[nidx(best_q)];
	assign push        = cmd.pick && have_best_q && !best_vis;
	assign out_free    = !out_valid_q || out_ready;

	assign wl_we    = cmd.walk_init || (push && (tail_q < NODES_P));
	assign wl_waddr = cmd.walk_init ? '0 : tail_q[NIW-1:0];
	assign wl_wdata = cmd.walk_init ? a_q : best_q;

	always_comb begin
		stat.mode       = mode_q;
		stat.a_ok       = node_ok(a_q);
		stat.b_ok       = node_ok(b_q);
		// a self loop needs two free entries in the same list
		if (a_q == b_q) begin
			stat.room = ({1'b0, du_q} + (DW + 1)'(2)) <= MAXD_C;
		end else begin
			stat.room = ({1'b0, du_q} < MAXD_C) && ({1'b0, sel_deg} < MAXD_C);
		end
		stat.list_empty = wk_q ? (tail_q == '0) : (head_q == tail_q);
		stat.out_free   = out_free;
		stat.pend_v     = pend_v_q;
		stat.idx_end    = (idx_q == dcur_q);
		stat.have_best  = have_best_q;
	end

	// neighbor table
	always_ff @(posedge clk) begin
		if (cmd.edge_wr) nbr_mem[nb_addr] <= nb_wdata;
		if (cmd.load_rd) nbr_rd_q <= nbr_mem[nb_addr];
	end

	// work list: queue or stack
	always_ff @(posedge clk) begin
		if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
		if (cmd.pop) wl_rd_q <= wl_mem[pop_pos[NIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_q        <= 1'b0;
			deg_q       <= '{default: '0};
			vis_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			ld_v_q      <= 1'b0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) wk_q <= cfg_wdata;

			if (cmd.deg_clear) begin
				deg_q <= '{default: '0};
			end else if (cmd.edge_wr) begin
				deg_q[nidx(sel_node)] <= sel_deg + DW'(1);
			end

			if (cmd.walk_init) begin
				// only the start node is marked
				vis_q    <= NODES'(1) << nidx(a_q);
				head_q   <= '0;
				tail_q   <= PW'(1);
				pend_v_q <= 1'b0;
			end else if (cmd.pop) begin
				if (wk_q) tail_q <= tail_q - PW'(1);
				else head_q <= head_q + PW'(1);
			end else if (push) begin
				vis_q[nidx(best_q)] <= 1'b1;
				if (tail_q < NODES_P) tail_q <= tail_q + PW'(1);
			end

			if (cmd.cur_latch) pend_v_q <= 1'b1;

			ld_v_q <= cmd.load_rd;

			if (cmd.scan_start) begin
				have_prev_q <= 1'b0;
				have_best_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (after_prev && before_best) have_best_q <= 1'b1;
			end else if (cmd.pick) begin
				if (have_best_q) have_prev_q <= 1'b1;
				have_best_q <= 1'b0;
			end

			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			a_q    <= node_a;
			b_q    <= node_b;
		end
		if (cmd.du_latch) du_q <= sel_deg;
		if (cmd.cur_latch) begin
			cur_q  <= wl_rd_q;
			pend_q <= wl_rd_q;
		end
		if (ld_v_q) row_q[ld_idx_q] <= nbr_rd_q;
		if (cmd.load_rd) ld_idx_q <= idx_q[RIW-1:0];

		if (cmd.load_start) begin
			dcur_q <= sel_deg;
			idx_q  <= '0;
		end else if (cmd.load_rd) begin
			idx_q <= idx_q + DW'(1);
		end else if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			if (after_prev && before_best) best_q <= row_v;
			idx_q <= idx_q + DW'(1);
		end else if (cmd.pick) begin
			if (have_best_q) prev_q <= best_q;
			idx_q <= '0;
		end

		if (cmd.out_load) begin
			out_node_q   <= (cmd.out_src == OUT_PEND) ? pend_q : '0;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_node   = out_node_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule
